FILE: src/ptrt_pkg.sv
// Shared types and constants of the periodic task ready table.
// Used by the command channel interface, the shared add/compare unit and the top level.
// No dependencies.
package ptrt_pkg;

  localparam int TASK_COUNT = 8;
  localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  localparam int CMD_W  = 3;
  localparam int TIDX_W = 8;
  localparam int STEP_W = 16;
  localparam int EV_W   = 8;
  localparam int TIME_W = 32;

  localparam logic [EV_W-1:0] EV_NONE = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_START     = 3'd1,
    CMD_CHECK     = 3'd2,
    CMD_SET       = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_CLEAR_ALL = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_POST
  } state_t;

  // operands of the shared add/compare unit
  typedef struct packed {
    logic [TIME_W-1:0] base;
    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] now;
  } alu_in_t;

  // results of the shared add/compare unit
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              due;
  } alu_out_t;

endpackage

FILE: src/ptrt_req_if.sv
// Command channel of the periodic task ready table: valid/ready plus payload.
// Depends on ptrt_pkg.
interface ptrt_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptrt_pkg::CMD_W-1:0]    cmd;
  logic [ptrt_pkg::TIDX_W-1:0]   task_index;
  logic                          periodic;
  logic [ptrt_pkg::STEP_W-1:0]   period_step;
  logic [ptrt_pkg::EV_W-1:0]     required_events;
  logic [ptrt_pkg::EV_W-1:0]     event_bits;
  logic [ptrt_pkg::TIME_W-1:0]   now_time;

  modport source (
    output valid, cmd, task_index, periodic, period_step, required_events, event_bits,
           now_time,
    input  ready
  );
  modport sink (
    input  valid, cmd, task_index, periodic, period_step, required_events, event_bits,
           now_time,
    output ready
  );
endinterface

FILE: src/ptrt_rsp_if.sv
// Result channel of the periodic task ready table: valid/ready plus payload.
// No dependencies.
interface ptrt_rsp_if;
  logic valid;
  logic ready;
  logic ok;
  logic bad_index;

  modport source (output valid, ok, bad_index, input ready);
  modport sink   (input valid, ok, bad_index, output ready);
endinterface

FILE: src/periodic_task_ready_table_core.sv
// Top level of the periodic task ready table: entry storage, sequencer, result register.
// Depends on ptrt_pkg, ptrt_req_if, ptrt_rsp_if and ptrt_alu.
//
//   channel  | dir | interface   | payload
//   ---------+-----+-------------+------------------------------------------------
//   req      | in  | ptrt_req_if | cmd, task_index, periodic, period_step,
//            |     |             | required_events, event_bits, now_time
//   rsp      | out | ptrt_rsp_if | ok, bad_index
//
// Sequence: add, check, set, clear, clear all and unused codes pass from accept through
//   the EXEC state, where the read-modify-write goes through the shared adder, to the
//   output register. Start walks the table in the WALK state, the shared adder updating
//   one entry per cycle, then the POST state posts the result.
// Reset: rst clears the sequencer, the result valid flag and every table entry at once.
// Stalls: the next command beat is taken while a result beat still waits in the
//   output register; a single-entry table update and the new result wait until that slot frees.
module periodic_task_ready_table_core (
  input  logic        clk,
  input  logic        rst,
  ptrt_req_if.sink    req,
  ptrt_rsp_if.source  rsp
);

  localparam logic [ptrt_pkg::IDX_W-1:0] LAST_SLOT = ptrt_pkg::IDX_W'(ptrt_pkg::TASK_COUNT - 1);
  localparam logic [ptrt_pkg::TIDX_W:0]  COUNT_LIM = (ptrt_pkg::TIDX_W+1)'(ptrt_pkg::TASK_COUNT);

  ptrt_pkg::state_t state, state_next;

  // captured command beat
  logic [ptrt_pkg::CMD_W-1:0]  cmd_q;
  logic [ptrt_pkg::TIDX_W-1:0] idx_q;
  logic                        per_q;
  logic [ptrt_pkg::STEP_W-1:0] step_q;
  logic [ptrt_pkg::EV_W-1:0]   need_q;
  logic [ptrt_pkg::EV_W-1:0]   ev_q;
  logic [ptrt_pkg::TIME_W-1:0] now_q;

  // task table
  logic                        is_periodic    [ptrt_pkg::TASK_COUNT];
  logic [ptrt_pkg::STEP_W-1:0] step_length    [ptrt_pkg::TASK_COUNT];
  logic [ptrt_pkg::EV_W-1:0]   pending_events [ptrt_pkg::TASK_COUNT];
  logic [ptrt_pkg::EV_W-1:0]   needed_events  [ptrt_pkg::TASK_COUNT];
  logic [ptrt_pkg::TIME_W-1:0] next_deadline  [ptrt_pkg::TASK_COUNT];

  logic [ptrt_pkg::IDX_W-1:0]  walk_cnt;
  logic [ptrt_pkg::IDX_W-1:0]  slot;

  logic rsp_valid, rsp_ok, rsp_bad;

  logic accept, slot_free, post, in_range, addressed, ready_now, ok_calc, bad_calc;

  ptrt_pkg::alu_in_t  alu_opnd;
  ptrt_pkg::alu_out_t alu_res;

  assign accept    = req.valid && req.ready;
  assign slot_free = !rsp_valid || rsp.ready;
  assign slot      = idx_q[ptrt_pkg::IDX_W-1:0];
  assign in_range  = ({1'b0, idx_q} < COUNT_LIM);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ptrt_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = (req.cmd == ptrt_pkg::CMD_START) ? ptrt_pkg::S_WALK : ptrt_pkg::S_EXEC;
        end
      end
      ptrt_pkg::S_EXEC: begin
        if (slot_free) state_next = ptrt_pkg::S_IDLE;
      end
      ptrt_pkg::S_WALK: begin
        if (walk_cnt == LAST_SLOT) state_next = ptrt_pkg::S_POST;
      end
      ptrt_pkg::S_POST: begin
        if (slot_free) state_next = ptrt_pkg::S_IDLE;
      end
      default: state_next = ptrt_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    req.ready = 1'b0;
    post      = 1'b0;
    case (state)
      ptrt_pkg::S_IDLE: req.ready = 1'b1;
      ptrt_pkg::S_EXEC: post      = slot_free;
      ptrt_pkg::S_POST: post      = slot_free;
      default: begin
        req.ready = 1'b0;
        post      = 1'b0;
      end
    endcase
  end

  // Steer the shared adder: the start walk adds each step to now; every other
  // command adds the addressed step to that entry's deadline.
  always_comb begin
    if (state == ptrt_pkg::S_WALK) begin
      alu_opnd.base = now_q;
      alu_opnd.step = step_length[walk_cnt];
    end else begin
      alu_opnd.base = next_deadline[slot];
      alu_opnd.step = step_length[slot];
    end
    alu_opnd.now = now_q;
  end

  ptrt_alu u_alu (
    .opnd (alu_opnd),
    .res  (alu_res)
  );

  // Ready: events match exactly, and a periodic task must also be due.
  assign ready_now = (pending_events[slot] == needed_events[slot]) &&
                     (!is_periodic[slot] || alu_res.due);

  // Result of a single-entry command; start and unused codes report nothing.
  always_comb begin
    addressed = 1'b0;
    case (cmd_q) inside
      ptrt_pkg::CMD_ADD, ptrt_pkg::CMD_CHECK, ptrt_pkg::CMD_SET,
      ptrt_pkg::CMD_CLEAR, ptrt_pkg::CMD_CLEAR_ALL: addressed = 1'b1;
      default: addressed = 1'b0;
    endcase
    bad_calc = addressed && !in_range;
    ok_calc  = 1'b0;
    if (in_range) begin
      case (cmd_q)
        ptrt_pkg::CMD_ADD:   ok_calc = 1'b1;
        ptrt_pkg::CMD_CHECK: ok_calc = ready_now;
        default:             ok_calc = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptrt_pkg::S_IDLE;
      walk_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        walk_cnt <= '0;
      end else if (state == ptrt_pkg::S_WALK && walk_cnt != LAST_SLOT) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  // hold the command beat for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      idx_q  <= req.task_index;
      per_q  <= req.periodic;
      step_q <= req.period_step;
      need_q <= req.required_events;
      ev_q   <= req.event_bits;
      now_q  <= req.now_time;
    end
  end

  // table update: start walk one entry per cycle, other commands at post time
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptrt_pkg::TASK_COUNT; i++) begin
        is_periodic[i]    <= 1'b0;
        step_length[i]    <= '0;
        pending_events[i] <= '0;
        needed_events[i]  <= '0;
        next_deadline[i]  <= '0;
      end
    end else if (state == ptrt_pkg::S_WALK) begin
      next_deadline[walk_cnt] <= alu_res.sum;
    end else if (state == ptrt_pkg::S_EXEC && post && in_range) begin
      case (cmd_q)
        ptrt_pkg::CMD_ADD: begin
          is_periodic[slot]    <= per_q;
          step_length[slot]    <= step_q;
          pending_events[slot] <= ev_q;
          needed_events[slot]  <= need_q;
        end
        ptrt_pkg::CMD_CHECK: begin
          if (ready_now && is_periodic[slot]) next_deadline[slot] <= alu_res.sum;
        end
        ptrt_pkg::CMD_SET: begin
          if (needed_events[slot] != ptrt_pkg::EV_NONE) begin
            pending_events[slot] <= pending_events[slot] | ev_q;
          end
        end
        ptrt_pkg::CMD_CLEAR: begin
          if (needed_events[slot] != ptrt_pkg::EV_NONE) begin
            pending_events[slot] <= pending_events[slot] & ~ev_q;
          end
        end
        ptrt_pkg::CMD_CLEAR_ALL: pending_events[slot] <= ptrt_pkg::EV_NONE;
        default: ;
      endcase
    end
  end

  // output register: one result beat per command
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (post) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      rsp_ok  <= (state == ptrt_pkg::S_EXEC) ? ok_calc  : 1'b0;
      rsp_bad <= (state == ptrt_pkg::S_EXEC) ? bad_calc : 1'b0;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.ok        = rsp_ok;
  assign rsp.bad_index = rsp_bad;

  // ---------------------------------------------------------------- assertions
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ptrt_pkg::S_IDLE))
    else $error("sequencer stayed idle after a command beat");

  a_walk_advances: assert property (@(posedge clk) disable iff (rst)
    (state == ptrt_pkg::S_WALK) && $past(state == ptrt_pkg::S_WALK) && !$past(rst)
    |-> (walk_cnt == $past(walk_cnt) + 1'b1))
    else $error("start walk skipped or repeated an entry");

  a_post_fills_slot: assert property (@(posedge clk) disable iff (rst)
    post |=> rsp_valid)
    else $error("posted result did not reach the output register");

  a_ok_excludes_bad: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_ok && rsp_bad))
    else $error("result reports success on a rejected index");

  a_post_only_when_free: assert property (@(posedge clk) disable iff (rst)
    post |-> slot_free)
    else $error("result overwrote a waiting beat");

endmodule

FILE: src/ptrt_alu.sv
// Shared 32-bit add/compare unit: base + step, and now >= base.
// Depends on ptrt_pkg.
module ptrt_alu (
  input  ptrt_pkg::alu_in_t  opnd,
  output ptrt_pkg::alu_out_t res
);

  assign res.sum = opnd.base + {{(ptrt_pkg::TIME_W-ptrt_pkg::STEP_W){1'b0}}, opnd.step};
  assign res.due = (opnd.now >= opnd.base);

endmodule

FILE: dv/ptrt_ready_monitor.sv
`timescale 1ns / 100ps
// Result monitor of the periodic task ready table: predicts every result beat and compares.
// Depends on ptrt_pkg, ptrt_req_if and ptrt_rsp_if.
module ptrt_ready_monitor (
  input  logic  clk,
  input  logic  rst,
  ptrt_req_if   req,
  ptrt_rsp_if   rsp,
  output int    fail_count,
  output int    outstanding
);
  import ptrt_pkg::*;

  typedef struct packed {
    logic ok;
    logic bad_index;
  } ready_result_t;

  // shadow copy of the task table
  logic              task_periodic [TASK_COUNT];
  logic [STEP_W-1:0] task_step     [TASK_COUNT];
  logic [EV_W-1:0]   task_pending  [TASK_COUNT];
  logic [EV_W-1:0]   task_needed   [TASK_COUNT];
  logic [TIME_W-1:0] task_deadline [TASK_COUNT];

  ready_result_t expected_results[$];
  int            result_count;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("mismatch at result %0d: %s got %0b want %0b", result_count, what, got, want);
    fail_count++;
  endtask

  // apply one command to the shadow table and return the result it should give
  function automatic ready_result_t apply_command(
    input logic [CMD_W-1:0]  cmd,
    input logic [TIDX_W-1:0] idx,
    input logic              per,
    input logic [STEP_W-1:0] step,
    input logic [EV_W-1:0]   need,
    input logic [EV_W-1:0]   ev,
    input logic [TIME_W-1:0] now
  );
    ready_result_t    r;
    logic [IDX_W-1:0] slot;
    r    = '0;
    slot = idx[IDX_W-1:0];
    if (cmd == CMD_START) begin
      for (int t = 0; t < TASK_COUNT; t++)
        task_deadline[t] = now + TIME_W'(task_step[t]);
    end else if (cmd <= CMD_CLEAR_ALL) begin
      if (idx >= TASK_COUNT) begin
        r.bad_index = 1'b1;
      end else begin
        case (cmd)
          CMD_ADD: begin
            task_periodic[slot] = per;
            task_step[slot]     = step;
            task_pending[slot]  = ev;
            task_needed[slot]   = need;
            r.ok                = 1'b1;
          end
          CMD_CHECK: begin
            if (task_pending[slot] == task_needed[slot] &&
                (!task_periodic[slot] || now >= task_deadline[slot])) begin
              r.ok = 1'b1;
              if (task_periodic[slot])
                task_deadline[slot] = task_deadline[slot] + TIME_W'(task_step[slot]);
            end
          end
          CMD_SET: begin
            if (task_needed[slot] != EV_NONE)
              task_pending[slot] = task_pending[slot] | ev;
          end
          CMD_CLEAR: begin
            if (task_needed[slot] != EV_NONE)
              task_pending[slot] = task_pending[slot] & ~ev;
          end
          default: begin
            task_pending[slot] = EV_NONE;
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ready_result_t want;
    if (rst) begin
      for (int t = 0; t < TASK_COUNT; t++) begin
        task_periodic[t] = 1'b0;
        task_step[t]     = '0;
        task_pending[t]  = '0;
        task_needed[t]   = '0;
        task_deadline[t] = '0;
      end
      expected_results.delete();
      result_count = 0;
      fail_count   = 0;
      outstanding <= 0;
    end else begin
      // retire the result beat first: it always belongs to an earlier command
      if (rsp.valid && rsp.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, ok", rsp.ok, 1'b0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch("ok", rsp.ok, want.ok);
          if (rsp.bad_index !== want.bad_index)
            report_mismatch("bad_index", rsp.bad_index, want.bad_index);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(apply_command(req.cmd, req.task_index, req.periodic,
                                                 req.period_step, req.required_events,
                                                 req.event_bits, req.now_time));
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the periodic task ready table testbench: clock, reset, command stimulus and verdict.
// Depends on ptrt_pkg, the channel interfaces, periodic_task_ready_table_core and ptrt_ready_monitor.
module tb_top;
  import ptrt_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int ITEMS_PER_PHASE = 420;
  localparam int HOLD_CYCLES     = 200;        // long receiver hold-off
  localparam int STALL_LIMIT     = 3000;       // cycles without any beat before giving up
  localparam int TAIL_CYCLES     = TASK_COUNT + 4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIDX_W-1:0] idx;
    logic              per;
    logic [STEP_W-1:0] step;
    logic [EV_W-1:0]   need;
    logic [EV_W-1:0]   ev;
    logic [TIME_W-1:0] now;
  } cmd_beat_t;

  logic clk;
  logic rst;

  ptrt_req_if req_ch ();
  ptrt_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;

  // idle percentages of each side; written only by the stimulus process
  int src_idle_pct;
  int dst_idle_pct;

  // hold-off requests: the stimulus bumps the count, the receiver serves it
  int hold_req_cnt;

  // stimulus-side view of the pattern each entry waits for, to steer set and clear
  logic [EV_W-1:0]   wait_pattern [TASK_COUNT];
  logic [TIME_W-1:0] clock_ms;

  int stall_cycles;

  periodic_task_ready_table_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ptrt_ready_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: drive ready at the falling edge. A pending hold-off request
  // drops ready for HOLD_CYCLES in a row so the block backs up and stalls
  // its command input; otherwise idle at random by dst_idle_pct.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  function automatic cmd_beat_t make_beat(
    input logic [CMD_W-1:0]  cmd,
    input logic [TIDX_W-1:0] idx,
    input logic              per,
    input logic [STEP_W-1:0] step,
    input logic [EV_W-1:0]   need,
    input logic [EV_W-1:0]   ev,
    input logic [TIME_W-1:0] now
  );
    cmd_beat_t b;
    b.cmd  = cmd;
    b.idx  = idx;
    b.per  = per;
    b.step = step;
    b.need = need;
    b.ev   = ev;
    b.now  = now;
    return b;
  endfunction

  // Build one random command. Most commands address a live entry with a
  // time near the running clock, so periodic checks actually come due;
  // set commands mostly deliver the pattern the entry waits for.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t         b;
    int                pick;
    logic [IDX_W-1:0]  slot;
    b    = '0;
    pick = $urandom_range(99);
    if      (pick < 15) b.cmd = CMD_ADD;
    else if (pick < 20) b.cmd = CMD_START;
    else if (pick < 55) b.cmd = CMD_CHECK;
    else if (pick < 72) b.cmd = CMD_SET;
    else if (pick < 84) b.cmd = CMD_CLEAR;
    else if (pick < 94) b.cmd = CMD_CLEAR_ALL;
    else if (pick < 97) b.cmd = CMD_SPARE_LO;
    else                b.cmd = CMD_SPARE_HI;

    b.idx = ($urandom_range(99) < 8) ? TIDX_W'($urandom_range(255))
                                     : TIDX_W'($urandom_range(TASK_COUNT - 1));
    slot  = b.idx[IDX_W-1:0];
    b.per = 1'($urandom_range(1));

    pick = $urandom_range(99);
    if      (pick < 10) b.step = STEP_W'($urandom_range(65535));
    else if (pick < 13) b.step = '1;
    else if (pick < 16) b.step = '0;
    else                b.step = STEP_W'($urandom_range(1500));

    pick = $urandom_range(99);
    if      (pick < 20) b.need = EV_NONE;
    else if (pick < 45) b.need = EV_W'($urandom_range(255));
    else if (pick < 50) b.need = '1;
    else                b.need = EV_W'(1 << $urandom_range(EV_W - 1)) |
                                 EV_W'(1 << $urandom_range(EV_W - 1));

    // content of the event field depends on what the command does with it
    case (b.cmd)
      CMD_ADD:   b.ev = ($urandom_range(1) == 0) ? b.need : EV_W'($urandom_range(255));
      CMD_SET:   b.ev = ($urandom_range(99) < 60 && b.idx < TASK_COUNT) ? wait_pattern[slot]
                                                                        : EV_W'($urandom_range(255));
      CMD_CLEAR: b.ev = ($urandom_range(1) == 0 && b.idx < TASK_COUNT) ? ~wait_pattern[slot]
                                                                       : EV_W'($urandom_range(255));
      default:   b.ev = EV_W'($urandom_range(255));
    endcase
    if (b.cmd == CMD_ADD && b.idx < TASK_COUNT)
      wait_pattern[slot] = b.need;

    // advance the running clock; sometimes look back or jump anywhere
    clock_ms = clock_ms + TIME_W'($urandom_range(400));
    pick     = $urandom_range(99);
    if      (pick < 6)  b.now = $urandom;
    else if (pick < 12) b.now = clock_ms - TIME_W'($urandom_range(2000));
    else                b.now = clock_ms;
    return b;
  endfunction

  // Offer one command beat. Idle at the falling edge by src_idle_pct, then
  // hold valid and payload until the block takes the beat. Valid stays high
  // after the beat; the next call lowers it only when it idles, and the end of stimulus lowers it.
  task automatic send_beat(input cmd_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.cmd             <= b.cmd;
    req_ch.task_index      <= b.idx;
    req_ch.periodic        <= b.per;
    req_ch.period_step     <= b.step;
    req_ch.required_events <= b.need;
    req_ch.event_bits      <= b.ev;
    req_ch.now_time        <= b.now;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    req_ch.valid           = 1'b0;
    req_ch.cmd             = CMD_ADD;
    req_ch.task_index      = '0;
    req_ch.periodic        = 1'b0;
    req_ch.period_step     = '0;
    req_ch.required_events = '0;
    req_ch.event_bits      = '0;
    req_ch.now_time        = '0;
    rst          = 1'b1;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_req_cnt = 0;
    clock_ms     = '0;
    for (int t = 0; t < TASK_COUNT; t++)
      wait_pattern[t] = EV_NONE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // an entry fresh from reset is aperiodic and waits for nothing: ready
    send_beat(make_beat(CMD_CHECK, 8'd0, 1'b0, '0, '0, '0, '0));
    // extremes of the add fields, plus an entry that already has unwanted events
    send_beat(make_beat(CMD_ADD, 8'd0, 1'b1, '1, '1, EV_NONE, '0));
    send_beat(make_beat(CMD_ADD, 8'd7, 1'b0, '0, EV_NONE, '1, '0));
    // index equal to the task count and the top index: rejected
    send_beat(make_beat(CMD_ADD, TIDX_W'(TASK_COUNT), 1'b1, '1, '1, '1, '1));
    send_beat(make_beat(CMD_ADD, '1, 1'b1, '1, '1, '1, '1));
    // start at the top of time: the deadline of entry 0 wraps
    send_beat(make_beat(CMD_START, '1, 1'b1, '1, '1, '1, '1));
    send_beat(make_beat(CMD_SET, 8'd0, 1'b0, '0, '0, '1, '0));
    // periodic entry with matching events: early, then due at the top of time
    send_beat(make_beat(CMD_CHECK, 8'd0, 1'b0, '0, '0, '0, '0));
    send_beat(make_beat(CMD_CHECK, 8'd0, 1'b0, '0, '0, '0, '1));
    // set and clear leave an entry that waits for nothing untouched
    send_beat(make_beat(CMD_SET, 8'd7, 1'b0, '0, '0, 8'h01, '0));
    send_beat(make_beat(CMD_CLEAR, 8'd7, 1'b0, '0, '0, '1, '0));
    send_beat(make_beat(CMD_CHECK, 8'd7, 1'b0, '0, '0, '0, '0));
    // clear all does not care about the needed pattern
    send_beat(make_beat(CMD_CLEAR_ALL, 8'd7, 1'b0, '0, '0, '0, '0));
    send_beat(make_beat(CMD_CHECK, 8'd7, 1'b0, '0, '0, '0, '0));
    send_beat(make_beat(CMD_CLEAR, 8'd0, 1'b0, '0, '0, 8'h0F, '0));
    send_beat(make_beat(CMD_CHECK, 8'd0, 1'b0, '0, '0, '0, '1));
    // out-of-range index on the other addressing commands
    send_beat(make_beat(CMD_SET, TIDX_W'(TASK_COUNT), 1'b0, '0, '0, '1, '0));
    send_beat(make_beat(CMD_CLEAR, 8'd200, 1'b0, '0, '0, '1, '0));
    send_beat(make_beat(CMD_CLEAR_ALL, TIDX_W'(TASK_COUNT), 1'b0, '0, '0, '0, '0));
    send_beat(make_beat(CMD_CHECK, '1, 1'b0, '0, '0, '0, '1));
    // unused codes are no-ops even with a bad index
    send_beat(make_beat(CMD_SPARE_LO, '1, 1'b1, '1, '1, '1, '1));
    send_beat(make_beat(CMD_SPARE_HI, 8'd0, 1'b1, '1, '1, '1, '1));
    // start at zero, then a periodic entry with a zero step is due at once
    send_beat(make_beat(CMD_START, 8'd0, 1'b0, '0, '0, '0, '0));
    send_beat(make_beat(CMD_ADD, 8'd3, 1'b1, '0, EV_NONE, EV_NONE, '0));
    send_beat(make_beat(CMD_CHECK, 8'd3, 1'b0, '0, '0, '0, '0));

    // --- random part, three idling phases ---
    // phase one: sender mostly busy, receiver mostly idle
    src_idle_pct = 13;
    dst_idle_pct = 70;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i == ITEMS_PER_PHASE / 2)
        hold_req_cnt++;
      send_beat(random_beat());
    end

    // phase two: the other way round; run the clock across the wrap
    src_idle_pct = 70;
    dst_idle_pct = 13;
    clock_ms     = 32'hFFFF_0000;
    for (int i = 0; i < ITEMS_PER_PHASE; i++)
      send_beat(random_beat());

    // phase three: no idling, opened by a long receiver hold-off
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_req_cnt++;
    for (int i = 0; i < ITEMS_PER_PHASE; i++)
      send_beat(random_beat());

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // drain: wait for every expected result, then let the pipeline settle
    while (outstanding != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
